[src/arc_pkg.sv]
// shared constants, register indexes and control/status structs
// for the 16 kHz nearest-neighbor rate converter; no dependencies
package arc_pkg;

  localparam int SAMPLE_W        = 8;
  localparam int RATE_W          = 16;
  localparam int LEN_W           = 24;
  localparam int IDX_W           = 26;
  localparam int DATA_W          = 32;
  localparam int ADDR_W          = 3;
  localparam int CNT_W           = 3;
  localparam int MAX_OUT         = 5;
  localparam int TARGET_RATE_DEF = 16000;
  localparam int FRAC_BITS_DEF   = 10;
  localparam int MIN_RATE        = 4000;
  localparam int RATE_RESET      = 16000;
  localparam int LEN_RESET       = 1;

  localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 8'h80;

  // register index, taken from paddr[2]
  localparam logic REG_SOURCE_RATE  = 1'b0;
  localparam logic REG_INPUT_LENGTH = 1'b1;

  // conversion mode
  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_UP   = 2'd1;
  localparam logic [1:0] MODE_DOWN = 2'd2;

  // divider operand select
  localparam logic DIV_TOTAL = 1'b0;
  localparam logic DIV_STEP  = 1'b1;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_sel;
    logic load_total;
    logic load_step;
    logic init;
    logic emit_pass;
    logic up_emit;
    logic dn_first;
    logic dn_last;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic       first;
    logic       last;
    logic [1:0] mode;
    logic       up_cond;
    logic       dn_c1;
    logic       dn_c2;
    logic       out_free;
    logic       div_busy;
    logic       div_done;
  } stat_t;

endpackage

[src/arc_regs.sv]
// configuration registers behind the apb-style port
// depends on arc_pkg
module arc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [arc_pkg::ADDR_W-1:0]   paddr,
  input  logic [arc_pkg::DATA_W-1:0]   pwdata,
  output logic [arc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic [arc_pkg::RATE_W-1:0]   source_rate,
  output logic [arc_pkg::LEN_W-1:0]    input_length,
  output logic                         restart
);

  localparam int RW = arc_pkg::RATE_W;
  localparam int LW = arc_pkg::LEN_W;
  localparam int DW = arc_pkg::DATA_W;

  logic wr;
  logic sel;

  assign pready  = 1'b1;
  assign sel     = paddr[2];
  assign wr      = psel && penable && pwrite;
  assign restart = wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_rate  <= RW'(arc_pkg::RATE_RESET);
      input_length <= LW'(arc_pkg::LEN_RESET);
    end else if (wr) begin
      if (sel == arc_pkg::REG_SOURCE_RATE) begin
        source_rate <= pwdata[RW-1:0];
      end else begin
        input_length <= pwdata[LW-1:0];
      end
    end
  end

  always_comb begin
    if (sel == arc_pkg::REG_INPUT_LENGTH) begin
      prdata = DW'(input_length);
    end else begin
      prdata = DW'(source_rate);
    end
  end

endmodule

[src/arc_div.sv]
// restoring divider, one quotient bit per cycle
// no dependencies
module arc_div #(
  parameter int DW = 40,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvd;
  logic [VW-1:0] rem;
  logic [VW-1:0] dsr;
  logic [CW-1:0] cnt;
  logic [VW:0]   trial;
  logic          fits;

  assign trial    = {rem, dvd[DW-1]};
  assign fits     = trial >= {1'b0, dsr};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[DW-2:0], fits};
      if (fits) begin
        rem <= VW'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[VW-1:0];
      end
    end
  end

endmodule

[src/arc_dp.sv]
// datapath: phase accumulator, indexes, held sample, divider and output register
// depends on arc_pkg and arc_div
module arc_dp #(
  parameter int TARGET_RATE = arc_pkg::TARGET_RATE_DEF,
  parameter int FRAC_BITS   = arc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [arc_pkg::RATE_W-1:0]          source_rate,
  input  logic [arc_pkg::LEN_W-1:0]           input_length,
  input  logic                                restart,
  input  logic [arc_pkg::SAMPLE_W-1:0]        sample_in,
  input  arc_pkg::cmd_t                       cmd,
  output arc_pkg::stat_t                      stat,
  output logic                                dst_valid,
  input  logic                                dst_ready,
  output logic signed [arc_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                final_res
);

  localparam int RW    = arc_pkg::RATE_W;
  localparam int LW    = arc_pkg::LEN_W;
  localparam int XW    = arc_pkg::IDX_W;
  localparam int SW    = arc_pkg::SAMPLE_W;
  localparam int ACC_W = XW + FRAC_BITS;
  localparam int DIV_W = (LW + RW > RW + FRAC_BITS) ? LW + RW : RW + FRAC_BITS;

  localparam logic [RW-1:0] TGT = RW'(TARGET_RATE);

  logic [RW-1:0]    rate_eff;
  logic [LW-1:0]    len_eff;
  logic [LW-1:0]    in_idx;
  logic [XW-1:0]    total;
  logic [FRAC_BITS-1:0] step;
  logic [ACC_W-1:0] acc;
  logic [XW-1:0]    out_idx;
  logic [SW-1:0]    held;
  logic             held_valid;
  logic [SW-1:0]    smp;
  logic [XW-1:0]    pos;
  logic [XW:0]      out_idx_inc;
  logic             fin_up;
  logic             fin1;
  logic             emit;
  logic [SW-1:0]    emit_data;
  logic             emit_fin;
  logic [DIV_W-1:0] div_dividend;
  logic [RW-1:0]    div_divisor;
  logic [DIV_W-1:0] div_q;
  logic [DIV_W-1:0] len_prod;
  logic             div_busy;
  logic             div_done;

  assign rate_eff    = (source_rate < RW'(arc_pkg::MIN_RATE)) ? RW'(arc_pkg::MIN_RATE)
                                                               : source_rate;
  assign len_eff     = (input_length == '0) ? LW'(1) : input_length;
  assign pos         = acc[ACC_W-1:FRAC_BITS];
  assign out_idx_inc = {1'b0, out_idx} + 1'b1;
  assign fin_up      = out_idx_inc == {1'b0, total};
  assign fin1        = fin_up || (stat.last && !(pos < total));

  always_comb begin
    stat          = '0;
    stat.first    = in_idx == '0;
    stat.last     = ({1'b0, in_idx} + 1'b1) >= {1'b0, len_eff};
    if (rate_eff == TGT) begin
      stat.mode = arc_pkg::MODE_PASS;
    end else if (rate_eff < TGT) begin
      stat.mode = arc_pkg::MODE_UP;
    end else begin
      stat.mode = arc_pkg::MODE_DOWN;
    end
    stat.up_cond  = (out_idx < total) && (pos == XW'(in_idx));
    stat.dn_c1    = held_valid && (pos != out_idx) && (out_idx < total);
    stat.dn_c2    = out_idx < total;
    stat.out_free = !dst_valid || dst_ready;
    stat.div_busy = div_busy;
    stat.div_done = div_done;
  end

  // divider operands
  assign len_prod = DIV_W'(len_eff) * DIV_W'(TGT);

  always_comb begin
    if (cmd.div_sel == arc_pkg::DIV_TOTAL) begin
      div_dividend = len_prod;
      div_divisor  = rate_eff;
    end else if (rate_eff < TGT) begin
      div_dividend = DIV_W'(rate_eff) << FRAC_BITS;
      div_divisor  = TGT;
    end else begin
      div_dividend = DIV_W'(TGT) << FRAC_BITS;
      div_divisor  = rate_eff;
    end
  end

  arc_div #(
    .DW(DIV_W),
    .VW(RW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_idx     <= '0;
      held_valid <= 1'b0;
    end else begin
      if (restart) begin
        in_idx <= '0;
      end else if (cmd.advance) begin
        in_idx <= stat.last ? '0 : in_idx + 1'b1;
      end
      if (cmd.init || cmd.dn_last) begin
        held_valid <= 1'b0;
      end else if (cmd.dn_first) begin
        held_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      smp <= sample_in;
    end
    if (cmd.load_total) begin
      if (div_q[DIV_W-1:XW] != '0) begin
        total <= '1;
      end else begin
        total <= div_q[XW-1:0];
      end
    end
    if (cmd.load_step) begin
      step <= div_q[FRAC_BITS-1:0];
    end
    if (cmd.init) begin
      acc     <= '0;
      out_idx <= '0;
    end else if (cmd.up_emit) begin
      acc     <= acc + ACC_W'(step);
      out_idx <= out_idx_inc[XW-1:0];
    end else if (cmd.dn_first) begin
      acc     <= acc + ACC_W'(step);
      out_idx <= pos;
    end
    if (cmd.dn_first) begin
      held <= smp;
    end
  end

  // output register
  always_comb begin
    emit      = 1'b0;
    emit_data = smp;
    emit_fin  = 1'b0;
    if (cmd.emit_pass) begin
      emit     = 1'b1;
      emit_fin = stat.last;
    end else if (cmd.up_emit) begin
      emit     = 1'b1;
      emit_fin = fin_up;
    end else if (cmd.dn_first) begin
      emit      = stat.dn_c1;
      emit_data = held;
      emit_fin  = fin1;
    end else if (cmd.dn_last) begin
      emit     = stat.dn_c2;
      emit_fin = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (emit) begin
      dst_valid <= 1'b1;
    end else if (dst_ready) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      sample_out <= $signed(emit_data ^ arc_pkg::SIGN_FLIP);
      final_res  <= emit_fin;
    end
  end

endmodule

[src/arc_ctrl.sv]
// controller: sequences setup divisions and per-request output emission
// depends on arc_pkg
module arc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           src_valid,
  output logic           src_ready,
  input  arc_pkg::stat_t stat,
  output arc_pkg::cmd_t  cmd
);

  localparam int CW = arc_pkg::CNT_W;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_TOT_GO    = 4'd1;
  localparam logic [3:0] S_TOT_WAIT  = 4'd2;
  localparam logic [3:0] S_STEP_GO   = 4'd3;
  localparam logic [3:0] S_STEP_WAIT = 4'd4;
  localparam logic [3:0] S_EVAL      = 4'd5;
  localparam logic [3:0] S_UP        = 4'd6;
  localparam logic [3:0] S_DN1       = 4'd7;
  localparam logic [3:0] S_DN2       = 4'd8;
  localparam logic [3:0] S_ADV       = 4'd9;

  logic [3:0]    state;
  logic [3:0]    state_next;
  logic [CW-1:0] n;
  logic [CW-1:0] n_next;

  assign src_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    n_next     = n;
    case (state)
      S_IDLE: begin
        if (src_valid) begin
          cmd.accept = 1'b1;
          state_next = stat.first ? S_TOT_GO : S_EVAL;
        end
      end
      S_TOT_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = arc_pkg::DIV_TOTAL;
        state_next    = S_TOT_WAIT;
      end
      S_TOT_WAIT: begin
        if (stat.div_done) begin
          cmd.load_total = 1'b1;
          state_next     = S_STEP_GO;
        end
      end
      S_STEP_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = arc_pkg::DIV_STEP;
        state_next    = S_STEP_WAIT;
      end
      S_STEP_WAIT: begin
        cmd.div_sel = arc_pkg::DIV_STEP;
        if (stat.div_done) begin
          cmd.load_step = 1'b1;
          cmd.init      = 1'b1;
          state_next    = S_EVAL;
        end
      end
      S_EVAL: begin
        n_next = '0;
        if (stat.mode == arc_pkg::MODE_PASS) begin
          if (stat.out_free) begin
            cmd.emit_pass = 1'b1;
            state_next    = S_ADV;
          end
        end else if (stat.mode == arc_pkg::MODE_UP) begin
          state_next = S_UP;
        end else begin
          state_next = S_DN1;
        end
      end
      S_UP: begin
        if (stat.up_cond && (n < CW'(arc_pkg::MAX_OUT))) begin
          if (stat.out_free) begin
            cmd.up_emit = 1'b1;
            n_next      = n + 1'b1;
          end
        end else begin
          state_next = S_ADV;
        end
      end
      S_DN1: begin
        if (!stat.dn_c1 || stat.out_free) begin
          cmd.dn_first = 1'b1;
          state_next   = stat.last ? S_DN2 : S_ADV;
        end
      end
      S_DN2: begin
        if (!stat.dn_c2 || stat.out_free) begin
          cmd.dn_last = 1'b1;
          state_next  = S_ADV;
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n     <= '0;
    end else begin
      state <= state_next;
      n     <= n_next;
    end
  end

endmodule

[src/audio_rate_converter_16k_top.sv]
// top level of the nearest-neighbor converter to TARGET_RATE (16 kHz)
// depends on arc_pkg, arc_regs, arc_ctrl, arc_dp (and arc_div through arc_dp)
//
// usage
//   write source_rate (address 0) and input_length (address 4) over the apb port
//   while idle; any write starts a new sound. samples enter on src_valid/src_ready,
//   one request at a time; converted signed samples leave on dst_valid/dst_ready,
//   final_res marks the last sample of the sound.
// sequencing
//   the first request of a sound runs two divisions on a bit-serial divider
//   (output count, then step) before its results. for other requests, pass-through
//   runs S_EVAL and S_ADV; upsampling runs S_EVAL, S_UP for each result (up to 5
//   results) and S_ADV; downsampling runs S_EVAL, S_DN1, S_DN2 only on the last
//   request of a sound, then S_ADV; the controller handles one request at a time.
// reset and stall
//   reset loads source_rate 16000, input_length 1 and starts a new sound.
//   results sit in one output register; while the receiver stalls with a result
//   pending, the controller waits before writing the next one, and src_ready
//   stays low until the request's results are all written.
module audio_rate_converter_16k_top #(
  parameter int TARGET_RATE = arc_pkg::TARGET_RATE_DEF,
  parameter int FRAC_BITS   = arc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [arc_pkg::ADDR_W-1:0]          paddr,
  input  logic [arc_pkg::DATA_W-1:0]          pwdata,
  output logic [arc_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  input  logic                                src_valid,
  output logic                                src_ready,
  input  logic [arc_pkg::SAMPLE_W-1:0]        sample_in,
  output logic                                dst_valid,
  input  logic                                dst_ready,
  output logic signed [arc_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                final_res
);

  logic [arc_pkg::RATE_W-1:0] source_rate;
  logic [arc_pkg::LEN_W-1:0]  input_length;
  logic                       restart;
  arc_pkg::cmd_t              cmd;
  arc_pkg::stat_t             stat;

  arc_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .source_rate  (source_rate),
    .input_length (input_length),
    .restart      (restart)
  );

  arc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  arc_dp #(
    .TARGET_RATE (TARGET_RATE),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .source_rate  (source_rate),
    .input_length (input_length),
    .restart      (restart),
    .sample_in    (sample_in),
    .cmd          (cmd),
    .stat         (stat),
    .dst_valid    (dst_valid),
    .dst_ready    (dst_ready),
    .sample_out   (sample_out),
    .final_res    (final_res)
  );

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_pass || cmd.up_emit) |-> stat.out_free)
    else $error("result written over a pending result");

  a_one_update: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.init, cmd.emit_pass, cmd.up_emit, cmd.dn_first, cmd.dn_last}))
    else $error("conflicting datapath commands");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (src_valid && src_ready) |=> !src_ready)
    else $error("request taken while another is in progress");

endmodule
